/* sv/lfu_pkg.sv */
// Package for the LFU cache with LRU tie-break.
// Holds widths, the entry record type and the sequencer state type. No dependencies.
`default_nettype none
package lfu_pkg;
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int CNT_W      = 16;
  localparam int STAMP_W    = 48;
  localparam int CFG_W      = 5;
  localparam int CAPACITY_DEF = 16;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
  localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [CNT_W-1:0]   count;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic   en;
    entry_t data;
  } wr_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_t;
endpackage
`default_nettype wire

/* sv/lfu_if.sv */
// Channel interfaces of the LFU cache: request and response.
// Depends on nothing but plain logic types.
`default_nettype none
interface lfu_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] key;
  logic [31:0] value;
  modport source(output valid, operation, key, value, input ready);
  modport sink(input valid, operation, key, value, output ready);
endinterface

interface lfu_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [31:0] read_value;
  logic        evicted;
  logic [31:0] evicted_key;
  modport source(output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink(input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface
`default_nettype wire

/* sv/lfu_store.sv */
// Entry memory of the LFU cache: one read port with registered data, one write port.
// Depends on lfu_pkg.
`default_nettype none
module lfu_store #(
  parameter int CAPACITY = lfu_pkg::CAPACITY_DEF,
  parameter int IDX_W    = 4
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  rd_en,
  input  wire [IDX_W-1:0]      rd_idx,
  input  lfu_pkg::wr_req_t     wr,
  input  wire [IDX_W-1:0]      wr_idx,
  output lfu_pkg::entry_t      rd_data_r,
  output logic                 rd_vld_r,
  output logic [IDX_W-1:0]     rd_idx_r
);
  import lfu_pkg::*;

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_idx] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
    rd_idx_r <= rd_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
    end
  end
endmodule
`default_nettype wire

/* sv/lfu_cache_with_lru_tiebreak_unit.sv */
// Top level of the LFU cache with LRU tie-break: sequencer, scan logic and result register.
// Depends on lfu_pkg, lfu_if (lfu_req_if, lfu_rsp_if) and lfu_store.
//
// Usage. Requests arrive on in_req as beats of {operation, key, value}; a get has
// operation 0, a put operation 1. Each accepted beat yields exactly one beat on out_rsp
// carrying {hit, read_value, evicted, evicted_key}. The single register capacity_in_use
// is written through cfg_wr_en / cfg_wr_data; the user writes it only while the block
// is idle, which the block itself does not enforce.
// Sequence. After acceptance the sequencer reads every entry of the entry memory through
// its one read port, one entry per cycle, waits for the last read data, and then makes
// the decision and the write-back in ST_DECIDE. The next request is accepted only once
// the sequencer is back in idle, so a new item is not taken before the last is through.
// Reset. rst_n is synchronous, active low. It clears all valid bits (flip-flops beside
// the memory), the access clock and sets capacity_in_use to 16. Memory contents are
// not cleared; invalid entries are never used.
// Stalls. The result sits in an output register. A new request is accepted while the
// previous result is being taken in the same cycle; if the receiver holds out_rsp.ready
// low the result stays and no new request is accepted.
`default_nettype none
module lfu_cache_with_lru_tiebreak_unit #(
  parameter int CAPACITY = lfu_pkg::CAPACITY_DEF
) (
  input  wire                       clk,
  input  wire                       rst_n,
  lfu_req_if.sink                   in_req,
  lfu_rsp_if.source                 out_rsp,
  input  wire                       cfg_wr_en,
  input  wire [lfu_pkg::CFG_W-1:0]  cfg_wr_data
);
  import lfu_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int USE_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (USE_W > CFG_W) ? USE_W : CFG_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CMP_W-1:0] CAP_CMP  = CMP_W'(CAPACITY);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]   cap_cfg_r;
  logic [STAMP_W-1:0] clock_r;
  logic [CAPACITY-1:0] valid_r;

  // Current request.
  logic               op_r;
  logic [KEY_W-1:0]   key_r;
  logic [VAL_W-1:0]   val_r;

  // Scan bookkeeping.
  logic [IDX_W-1:0]   addr_r;
  logic               issue_done_r;
  logic [USE_W-1:0]   used_r;
  logic               match_found_r;
  logic [IDX_W-1:0]   match_idx_r;
  entry_t             match_ent_r;
  logic               free_found_r;
  logic [IDX_W-1:0]   free_idx_r;
  logic               vic_found_r;
  logic [IDX_W-1:0]   vic_idx_r;
  entry_t             vic_ent_r;

  // Result register.
  logic               out_valid_r;
  logic               out_hit_r;
  logic [VAL_W-1:0]   out_val_r;
  logic               out_ev_r;
  logic [KEY_W-1:0]   out_evkey_r;

  // Memory ports.
  logic               rd_en;
  entry_t             rd_data;
  logic               rd_vld;
  logic [IDX_W-1:0]   rd_idx;
  wr_req_t            wr;
  logic [IDX_W-1:0]   wr_idx;

  logic in_acc;
  logic last_beat;

  assign in_req.ready = (state_r == ST_IDLE) && (!out_valid_r || out_rsp.ready);
  assign in_acc       = in_req.valid && in_req.ready;
  assign rd_en        = (state_r == ST_SCAN) && !issue_done_r;
  assign last_beat    = rd_vld && (rd_idx == LAST_IDX);

  lfu_store #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (rd_en),
    .rd_idx    (addr_r),
    .wr        (wr),
    .wr_idx    (wr_idx),
    .rd_data_r (rd_data),
    .rd_vld_r  (rd_vld),
    .rd_idx_r  (rd_idx)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_SCAN;
      ST_SCAN:   if (last_beat) state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Per-beat scan: first matching key, first free slot, and the victim with the
  // smallest count, the oldest stamp breaking ties and the lowest index after that.
  logic beat_valid;
  logic beat_better;
  always_comb begin
    beat_valid  = valid_r[rd_idx];
    beat_better = !vic_found_r || (rd_data.count < vic_ent_r.count) ||
                  ((rd_data.count == vic_ent_r.count) &&
                   (rd_data.stamp < vic_ent_r.stamp));
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_req.operation;
      key_r <= in_req.key;
      val_r <= in_req.value;
    end
    if (rd_vld && beat_valid) begin
      if (!match_found_r && (rd_data.key == key_r)) begin
        match_idx_r <= rd_idx;
        match_ent_r <= rd_data;
      end
      if (beat_better) begin
        vic_idx_r <= rd_idx;
        vic_ent_r <= rd_data;
      end
    end
    if (rd_vld && !beat_valid && !free_found_r) begin
      free_idx_r <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r        <= '0;
      issue_done_r  <= 1'b0;
      used_r        <= '0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      vic_found_r   <= 1'b0;
    end else if (in_acc) begin
      addr_r        <= '0;
      issue_done_r  <= 1'b0;
      used_r        <= '0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      vic_found_r   <= 1'b0;
    end else begin
      if (rd_en) begin
        if (addr_r == LAST_IDX) begin
          issue_done_r <= 1'b1;
        end else begin
          addr_r <= addr_r + IDX_W'(1);
        end
      end
      if (rd_vld) begin
        if (beat_valid) begin
          used_r      <= used_r + USE_W'(1);
          vic_found_r <= 1'b1;
          if (rd_data.key == key_r) begin
            match_found_r <= 1'b1;
          end
        end else begin
          free_found_r <= 1'b1;
        end
      end
    end
  end

  // Decision and write-back, done in ST_DECIDE.
  logic [CMP_W-1:0]   cap_eff;
  logic [CMP_W-1:0]   used_ext;
  logic               is_dec;
  logic               do_touch;
  logic               do_insert;
  logic               do_evict;
  logic               room_short;
  logic [IDX_W-1:0]   ins_idx;
  logic [CNT_W-1:0]   touched_cnt;

  always_comb begin
    cap_eff     = (CMP_W'(cap_cfg_r) > CAP_CMP) ? CAP_CMP : CMP_W'(cap_cfg_r);
    used_ext    = CMP_W'(used_r);
    is_dec      = (state_r == ST_DECIDE);
    room_short  = (used_ext >= cap_eff) || !free_found_r;
    do_touch    = 1'b0;
    do_insert   = 1'b0;
    do_evict    = 1'b0;
    ins_idx     = free_idx_r;
    priority if (op_r == OP_GET) begin
      do_touch = match_found_r;
    end else if (cap_eff == '0) begin
      do_touch = 1'b0;
    end else if (match_found_r) begin
      do_touch = 1'b1;
    end else begin
      do_evict  = room_short && vic_found_r;
      if (do_evict) begin
        ins_idx = vic_idx_r;
      end
      do_insert = free_found_r || do_evict;
    end
    touched_cnt = (match_ent_r.count == COUNT_MAX) ? COUNT_MAX
                                                   : match_ent_r.count + CNT_W'(1);

    wr.en         = is_dec && (do_touch || do_insert);
    wr.data.key   = do_insert ? key_r : match_ent_r.key;
    wr.data.value = (op_r == OP_PUT) ? val_r : match_ent_r.value;
    wr.data.count = do_insert ? CNT_W'(1) : touched_cnt;
    wr.data.stamp = clock_r;
    wr_idx        = do_insert ? ins_idx : match_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      clock_r   <= '0;
      cap_cfg_r <= CFG_RESET;
    end else begin
      if (cfg_wr_en) begin
        cap_cfg_r <= cfg_wr_data;
      end
      if (wr.en) begin
        clock_r <= clock_r + STAMP_W'(1);
      end
      // An eviction always reuses the victim's slot for the new entry, so that slot
      // simply stays valid.
      if (is_dec && do_insert) begin
        valid_r[ins_idx] <= 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (is_dec) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_dec) begin
      out_hit_r   <= match_found_r;
      out_val_r   <= ((op_r == OP_GET) && match_found_r) ? match_ent_r.value : '0;
      out_ev_r    <= do_evict;
      out_evkey_r <= do_evict ? vic_ent_r.key : '0;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.hit         = out_hit_r;
  assign out_rsp.read_value  = out_val_r;
  assign out_rsp.evicted     = out_ev_r;
  assign out_rsp.evicted_key = out_evkey_r;

  // An accepted request always starts a scan.
  a_acc_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_SCAN))
    else $error("accepted request did not start a scan");

  // Every decision leaves a result waiting in the output register.
  a_dec_out: assert property (@(posedge clk) disable iff (!rst_n)
    is_dec |=> out_valid_r)
    else $error("decision did not produce a result");

  // The entry memory is written only during the decision cycle.
  a_wr_dec: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> is_dec)
    else $error("memory written outside the decision cycle");

  // No read is issued while a decision writes back.
  a_no_rd_dec: assert property (@(posedge clk) disable iff (!rst_n)
    is_dec |-> !rd_en)
    else $error("read overlaps write-back");
endmodule
`default_nettype wire
